// ----- design/spms_pkg.sv -----
// ----------------------------------------------------------------------------
// spms_pkg
// Types and fixed constants shared by the multi-stack pool block.
// ----------------------------------------------------------------------------
`default_nettype none

package spms_pkg;

  localparam int unsigned MODE_W   = 1;
  localparam int unsigned SID_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  pop_value;
  } rsp_t;

endpackage

`default_nettype wire

// ----- design/spms_req_if.sv -----
// ----------------------------------------------------------------------------
// spms_req_if
// Request channel: one stack operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface spms_req_if;

  logic                                 valid;
  logic                                 ready;
  logic [spms_pkg::MODE_W-1:0]          mode;
  logic [spms_pkg::SID_W-1:0]           stack_id;
  logic signed [spms_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output mode, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input mode, input stack_id, input push_value,
                  output ready);

endinterface

`default_nettype wire

// ----- design/spms_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spms_rsp_if
// Response channel: status and popped value, one per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface spms_rsp_if;

  logic                                 valid;
  logic                                 ready;
  logic [spms_pkg::STATUS_W-1:0]        status;
  logic signed [spms_pkg::VALUE_W-1:0]  pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);

endinterface

`default_nettype wire

// ----- design/shared_pool_multi_stack.sv -----
// ----------------------------------------------------------------------------
// shared_pool_multi_stack
// Several LIFO stacks sharing one pool of slots through a linked free list.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transfer: mode (push or pop), stack_id
//   and push_value. rsp_o returns one transfer per request, in order: status
//   (ok, overflow on push, underflow on pop) and pop_value (zero unless a
//   pop succeeds).
//   Timing: an accepted request moves to the execute state, and its result
//   is then loaded into the output register that drives the response.
//   Requests: the next request is taken only once the last one completes,
//   since it depends on the free or top slot that the link RAM read yields.
//   Reset: every stack is empty and all slots are free; no clearing pass is
//   needed, since a fresh-slot counter stands in for the initial free list.
//   Stall: the response sits in an output register; a new request may be
//   taken while it waits, and that request then holds in its execute cycle
//   until the receiver takes the waiting response.
//   An operation on a stack id at or beyond STACKS changes nothing and
//   reports overflow (push) or underflow (pop).
// ----------------------------------------------------------------------------
`default_nettype none

module shared_pool_multi_stack #(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned STACKS = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  spms_req_if.sink     req_i,
  spms_rsp_if.source   rsp_o
);

  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS);

  logic                              ram_rd_en;
  logic [IW-1:0]                     ram_rd_addr;
  logic [IW-1:0]                     ram_wr_addr;
  logic                              link_wr_en;
  logic [PW-1:0]                     link_wr_data;
  logic [PW-1:0]                     link_rd_data;
  logic                              val_wr_en;
  logic [spms_pkg::VALUE_W-1:0]      val_wr_data;
  logic [spms_pkg::VALUE_W-1:0]      val_rd_data;
  logic                              done;
  spms_pkg::rsp_t                    rsp_new;
  logic                              req_ready;

  // Output register state.
  logic           rsp_valid_q, rsp_valid_d;
  spms_pkg::rsp_t rsp_q;
  logic           out_free;

  assign req_i.ready = req_ready;

  // Sequencer: picks the slot, reads the RAMs, writes the relinked entry.
  spms_ctrl #(
    .SLOTS  (SLOTS),
    .STACKS (STACKS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_i.valid),
    .req_ready_o      (req_ready),
    .req_mode_i       (req_i.mode),
    .req_stack_id_i   (req_i.stack_id),
    .req_push_value_i (req_i.push_value),
    .out_free_i       (out_free),
    .done_o           (done),
    .rsp_o            (rsp_new),
    .ram_rd_en_o      (ram_rd_en),
    .ram_rd_addr_o    (ram_rd_addr),
    .ram_wr_addr_o    (ram_wr_addr),
    .link_wr_en_o     (link_wr_en),
    .link_wr_data_o   (link_wr_data),
    .link_rd_data_i   (link_rd_data),
    .val_wr_en_o      (val_wr_en),
    .val_wr_data_o    (val_wr_data),
    .val_rd_data_i    (val_rd_data)
  );

  // Link store: next pointer of each slot, null encoded as SLOTS.
  spms_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (link_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (link_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (link_rd_data)
  );

  // Value store: payload of each occupied slot.
  spms_ram #(
    .WIDTH (spms_pkg::VALUE_W),
    .DEPTH (SLOTS)
  ) u_value_ram (
    .clk_i     (clk_i),
    .wr_en_i   (val_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (val_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (val_rd_data)
  );

  // The register can take a new result when empty or draining this cycle.
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (done) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Load the payload on completion, hold it otherwise.
  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp_new;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.pop_value = rsp_q.pop_value;

endmodule

`default_nettype wire

// ----- design/spms_ram.sv -----
// ----------------------------------------------------------------------------
// spms_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module spms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/spms_ctrl.sv -----
// ----------------------------------------------------------------------------
// spms_ctrl
// Operation sequencer: holds stack heads, free-list head and fresh-slot
// count, reads the link/value RAMs and writes back the updated links.
// ----------------------------------------------------------------------------
`default_nettype none

module spms_ctrl #(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned STACKS = 4,
  localparam int unsigned PW    = $clog2(SLOTS + 1),
  localparam int unsigned IW    = $clog2(SLOTS)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  req_valid_i,
  output logic                                       req_ready_o,
  input  wire logic [spms_pkg::MODE_W-1:0]           req_mode_i,
  input  wire logic [spms_pkg::SID_W-1:0]            req_stack_id_i,
  input  wire logic signed [spms_pkg::VALUE_W-1:0]   req_push_value_i,
  input  wire logic                                  out_free_i,
  output logic                                       done_o,
  output spms_pkg::rsp_t                             rsp_o,
  output logic                                       ram_rd_en_o,
  output logic [IW-1:0]                              ram_rd_addr_o,
  output logic [IW-1:0]                              ram_wr_addr_o,
  output logic                                       link_wr_en_o,
  output logic [PW-1:0]                              link_wr_data_o,
  input  wire logic [PW-1:0]                         link_rd_data_i,
  output logic                                       val_wr_en_o,
  output logic [spms_pkg::VALUE_W-1:0]               val_wr_data_o,
  input  wire logic [spms_pkg::VALUE_W-1:0]          val_rd_data_i
);

  localparam int unsigned HW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

  spms_pkg::state_e state_q, state_d;

  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [PW-1:0] heads_q [STACKS];
  logic [PW-1:0] heads_d [STACKS];

  logic                                op_pop_q;
  logic [HW-1:0]                       op_sid_q;
  logic signed [spms_pkg::VALUE_W-1:0] op_val_q;
  logic [IW-1:0]                       op_slot_q;
  logic                                op_err_q;
  logic                                op_fresh_q;

  logic          accept;
  logic          req_pop;
  logic          sid_ok;
  logic [HW-1:0] sid_idx;
  logic [PW-1:0] head_sel;
  logic [PW-1:0] slot_ptr;
  logic          req_err;
  logic [PW-1:0] link_eff;
  logic          commit;

  assign req_pop  = (req_mode_i == spms_pkg::MODE_POP);
  assign sid_ok   = (32'(req_stack_id_i) < 32'(STACKS));
  assign sid_idx  = HW'(req_stack_id_i);
  assign head_sel = heads_q[sid_idx];
  assign slot_ptr = req_pop ? head_sel : free_head_q;
  assign req_err  = !sid_ok || (slot_ptr == NULL_PTR);
  assign accept   = req_valid_i && req_ready_o;

  // A slot never handed out still links to its successor; last one yields null.
  assign link_eff = op_fresh_q ? (PW'(op_slot_q) + PW'(1)) : link_rd_data_i;

  assign ram_rd_en_o    = accept && !req_err;
  assign ram_rd_addr_o  = slot_ptr[IW-1:0];
  assign ram_wr_addr_o  = op_slot_q;
  assign link_wr_data_o = op_pop_q ? free_head_q : heads_q[op_sid_q];
  assign val_wr_data_o  = op_val_q;

  always_comb begin
    state_d      = state_q;
    req_ready_o  = 1'b0;
    commit       = 1'b0;
    done_o       = 1'b0;
    link_wr_en_o = 1'b0;
    val_wr_en_o  = 1'b0;
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    heads_d      = heads_q;
    unique case (state_q)
      spms_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          state_d = spms_pkg::S_EXEC;
        end
      end
      spms_pkg::S_EXEC: begin
        // Hold here until the output register can take the result.
        if (out_free_i) begin
          commit  = 1'b1;
          done_o  = 1'b1;
          state_d = spms_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spms_pkg::S_IDLE;
      end
    endcase

    if (commit && !op_err_q) begin
      link_wr_en_o = 1'b1;
      if (op_pop_q) begin
        heads_d[op_sid_q] = link_eff;
        free_head_d       = PW'(op_slot_q);
      end else begin
        val_wr_en_o       = 1'b1;
        free_head_d       = link_eff;
        heads_d[op_sid_q] = PW'(op_slot_q);
        if (op_fresh_q) begin
          fill_d = fill_q + PW'(1);
        end
      end
    end
  end

  always_comb begin
    rsp_o.pop_value = '0;
    if (op_err_q) begin
      rsp_o.status = op_pop_q ? spms_pkg::STATUS_UNDERFLOW : spms_pkg::STATUS_OVERFLOW;
    end else begin
      rsp_o.status = spms_pkg::STATUS_OK;
      if (op_pop_q) begin
        rsp_o.pop_value = val_rd_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spms_pkg::S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      for (int i = 0; i < STACKS; i++) begin
        heads_q[i] <= NULL_PTR;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      heads_q     <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_pop_q   <= req_pop;
      op_sid_q   <= sid_idx;
      op_val_q   <= req_push_value_i;
      op_slot_q  <= slot_ptr[IW-1:0];
      op_err_q   <= req_err;
      op_fresh_q <= !req_pop && (slot_ptr >= fill_q);
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_shared_pool_multi_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_pool_multi_stack
// Self-checking bench for the multi-stack pool. A queue-fed driver issues
// push and pop requests, an in-bench model of the slot pool and its linked
// lists predicts each status and popped value, and a monitor checks every
// response transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_shared_pool_multi_stack;

  import spms_pkg::*;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned STACKS = 4;
  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  // The null link is one past the last real slot.
  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);
  localparam int unsigned PHASE_OPS   = 600;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic [LINK_W-1:0] link_t;

  typedef struct {
    mode_e                mode;
    logic [SID_W-1:0]     sid;
    logic [VALUE_W-1:0]   value;
  } stack_op_t;

  logic clk_i;
  logic rst_ni;

  spms_req_if req_bus ();
  spms_rsp_if rsp_bus ();

  shared_pool_multi_stack #(
    .SLOTS  (SLOTS),
    .STACKS (STACKS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // 12 ns period: 6 ns high, 6 ns low.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Pending operations for the driver, and responses the pool model owes.
  stack_op_t op_q[$];
  rsp_t      owed_rsp_q[$];

  // Pool model: values, next links, one top pointer per stack, free list head.
  logic [VALUE_W-1:0] slot_value[SLOTS];
  link_t              slot_link[SLOTS];
  link_t              stack_top[STACKS];
  link_t              free_head;

  // Idle percentages for the request side and the response side.
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Apply one operation to the pool model and return the response it owes.
  function automatic rsp_t apply_stack_op(input stack_op_t op);
    rsp_t  r;
    link_t slot;
    r.status    = STATUS_OK;
    r.pop_value = '0;
    if (op.mode == MODE_PUSH) begin
      if (op.sid >= STACKS || free_head == NIL) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        // Take the free head, store the value, link it on top of the stack.
        slot              = free_head;
        free_head         = slot_link[slot];
        slot_value[slot]  = op.value;
        slot_link[slot]   = stack_top[op.sid];
        stack_top[op.sid] = slot;
      end
    end else begin
      if (op.sid >= STACKS || stack_top[op.sid] == NIL) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        // Unlink the top slot and hand it back to the head of the free list.
        slot              = stack_top[op.sid];
        stack_top[op.sid] = slot_link[slot];
        slot_link[slot]   = free_head;
        free_head         = slot;
        r.pop_value       = slot_value[slot];
      end
    end
    return r;
  endfunction

  task automatic queue_op(input mode_e mode, input int unsigned sid,
                          input logic [VALUE_W-1:0] value);
    stack_op_t op;
    op.mode  = mode;
    op.sid   = SID_W'(sid);
    op.value = value;
    op_q.push_back(op);
  endtask

  // Random traffic in runs: push-heavy runs fill the pool into overflow,
  // pop-heavy runs drain stacks into underflow, balanced runs churn the lists.
  task automatic queue_random_ops(input int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned push_pct;
    int unsigned hot_sid;
    int unsigned sid;
    left = count;
    while (left != 0) begin
      run = $urandom_range(150, 40);
      if (run > left) run = left;
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      hot_sid = $urandom_range(STACKS - 1);
      repeat (run) begin
        // Lean on one stack half the time to build deep chains.
        sid = ($urandom_range(1) == 0) ? hot_sid : $urandom_range(3);
        queue_op(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP, sid, $urandom);
      end
      left -= run;
    end
  endtask

  // Request driver: hold the item until it transfers, then load the next.
  always @(posedge clk_i) begin
    stack_op_t op;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (op_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
        op = op_q.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= op.mode;
        req_bus.stack_id   <= op.sid;
        req_bus.push_value <= op.value;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response side back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Monitor: predict on each request transfer, check each response transfer.
  always @(posedge clk_i) begin
    stack_op_t op;
    rsp_t      want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        op.mode  = mode_e'(req_bus.mode);
        op.sid   = req_bus.stack_id;
        op.value = req_bus.push_value;
        owed_rsp_q.push_back(apply_stack_op(op));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("response transfer with nothing owed");
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_bus.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp_bus.status, want.status));
          if (rsp_bus.pop_value !== want.pop_value)
            report_mismatch($sformatf("pop_value got %h want %h",
                                      rsp_bus.pop_value, want.pop_value));
        end
      end
    end
  end

  // Watchdog: fail the run once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Known values on every block input before the first edge.
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.mode       = MODE_PUSH;
    req_bus.stack_id   = '0;
    req_bus.push_value = '0;
    rsp_bus.ready      = 1'b0;
    err_cnt            = 0;
    cycle_cnt          = 0;
    req_idle_pct       = 18;
    rsp_stall_pct      = 68;

    // Pool model after reset: all stacks empty, slots chained in order.
    for (int i = 0; i < SLOTS; i++) begin
      slot_value[i] = '0;
      slot_link[i]  = link_t'(i + 1);
    end
    slot_link[SLOTS-1] = NIL;
    for (int s = 0; s < STACKS; s++) stack_top[s] = NIL;
    free_head = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: pop every empty stack, push extreme values, then unwind
    // each stack to empty, and stacks 0, 1 and 3 past it, to check order and underflow.
    for (int s = 0; s < STACKS; s++) queue_op(MODE_POP, s, $urandom);
    queue_op(MODE_PUSH, 0, 32'h7fff_ffff);
    queue_op(MODE_PUSH, 1, 32'h8000_0000);
    queue_op(MODE_PUSH, 2, 32'h0000_0000);
    queue_op(MODE_PUSH, 3, 32'hffff_ffff);
    queue_op(MODE_PUSH, 0, 32'h5555_5555);
    queue_op(MODE_PUSH, 0, 32'haaaa_aaaa);
    queue_op(MODE_POP, 0, 32'hffff_ffff);
    queue_op(MODE_POP, 0, 32'h0000_0000);
    queue_op(MODE_POP, 0, $urandom);
    queue_op(MODE_POP, 0, $urandom);
    queue_op(MODE_POP, 1, $urandom);
    queue_op(MODE_POP, 1, $urandom);
    queue_op(MODE_POP, 2, $urandom);
    queue_op(MODE_POP, 3, $urandom);
    queue_op(MODE_POP, 3, $urandom);

    // Phase one: sender idles lightly, receiver stalls heavily.
    queue_random_ops(PHASE_OPS);
    while (op_q.size() != 0) @(negedge clk_i);

    // Phase two: the other way round.
    req_idle_pct  = 68;
    rsp_stall_pct = 18;
    queue_random_ops(PHASE_OPS);
    while (op_q.size() != 0) @(negedge clk_i);

    // Phase three: full rate on both sides.
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    queue_random_ops(PHASE_OPS);

    // Drain: every request transferred, every owed response seen.
    while (op_q.size() != 0 || req_bus.valid) @(negedge clk_i);
    while (owed_rsp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
